### design/descriptor_slot_free_list_allocator_defines.svh
// Assertion macros shared by the descriptor slot allocator modules.
`ifndef DESCRIPTOR_SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define DESCRIPTOR_SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define DSFL_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Check a consequence in the same cycle as its trigger.
`define DSFL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check a consequence in the cycle after its trigger.
`define DSFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/dsfl_pkg.sv
// Types, codes and constants for the descriptor slot allocator.
package dsfl_pkg;

  localparam int IDX_W  = 10;
  localparam int INC_W  = 11;
  localparam int ADDR_W = 48;
  localparam int ERR_W  = 3;
  localparam int CFG_IDX_W = 3;

  localparam int SRV_SLOTS_DEF = 1024;
  localparam int RTV_SLOTS_DEF = 512;
  localparam int DSV_SLOTS_DEF = 512;
  localparam bit SRV_SHADER_VISIBLE_DEF = 1'b1;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    POOL_SRV = 2'd0,
    POOL_RTV = 2'd1,
    POOL_DSV = 2'd2,
    POOL_BAD = 2'd3
  } pool_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 3'd0,
    ERR_EMPTY    = 3'd1,
    ERR_BAD_POOL = 3'd2,
    ERR_RANGE    = 3'd3,
    ERR_FULL     = 3'd4
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRV_INC      = 3'd0,
    REG_RTV_INC      = 3'd1,
    REG_DSV_INC      = 3'd2,
    REG_SRV_CPU_BASE = 3'd3,
    REG_RTV_CPU_BASE = 3'd4,
    REG_DSV_CPU_BASE = 3'd5,
    REG_SRV_GPU_BASE = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CALC
  } state_t;

  // Request from the control path to one free-list stack.
  typedef struct packed {
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] index;
  } stack_cmd_t;

  // Stack status; top_index is valid in the cycle after the top settles.
  typedef struct packed {
    logic             empty;
    logic             full;
    logic [IDX_W-1:0] top_index;
  } stack_stat_t;

endpackage

### design/descriptor_slot_free_list_allocator.sv
// Top level of the descriptor slot allocator: control, registers, handles.
// Each request goes through these steps from acceptance to a loaded result: the
// first reads the top entry of every pool's stack memory, the second
// decides the pop or push and writes the stack back, the third forms
// base + index * increment in one multiply-add into the output register.
// A new request is taken as soon as the previous one has loaded its result,
// even while that result still waits on out_ready; a request whose result
// cannot be loaded holds in its last step. After reset no clearing pass is
// run: each stack keeps a low mark of the lowest top it reached, and
// entries below it read as their reset index, so requests are accepted
// from the first cycle after reset.
`include "descriptor_slot_free_list_allocator_defines.svh"

module descriptor_slot_free_list_allocator #(
  parameter int SRV_SLOTS          = dsfl_pkg::SRV_SLOTS_DEF,
  parameter int RTV_SLOTS          = dsfl_pkg::RTV_SLOTS_DEF,
  parameter int DSV_SLOTS          = dsfl_pkg::DSV_SLOTS_DEF,
  parameter bit SRV_SHADER_VISIBLE = dsfl_pkg::SRV_SHADER_VISIBLE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [dsfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dsfl_pkg::ADDR_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic [1:0]                     pool,
  input  logic [dsfl_pkg::IDX_W-1:0]     slot_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           ok,
  output logic [dsfl_pkg::ERR_W-1:0]     error_code,
  output logic [dsfl_pkg::IDX_W-1:0]     granted_index,
  output logic [dsfl_pkg::ADDR_W-1:0]    cpu_handle,
  output logic [dsfl_pkg::ADDR_W-1:0]    gpu_handle
);
  import dsfl_pkg::*;

  // Configuration registers
  logic [INC_W-1:0]  srv_increment;
  logic [INC_W-1:0]  rtv_increment;
  logic [INC_W-1:0]  dsv_increment;
  logic [ADDR_W-1:0] srv_cpu_base;
  logic [ADDR_W-1:0] rtv_cpu_base;
  logic [ADDR_W-1:0] dsv_cpu_base;
  logic [ADDR_W-1:0] srv_gpu_base;

  // Control and captured request
  state_t            state;
  state_t            state_next;
  action_t           req_action;
  pool_t             req_pool;
  logic [IDX_W-1:0]  req_index;
  logic              load_out;

  // Stack interfaces
  stack_cmd_t        srv_cmd;
  stack_cmd_t        rtv_cmd;
  stack_cmd_t        dsv_cmd;
  stack_stat_t       srv_stat;
  stack_stat_t       rtv_stat;
  stack_stat_t       dsv_stat;

  // Decision step
  stack_stat_t       sel_stat;
  logic [IDX_W:0]    sel_slots;
  logic [INC_W-1:0]  sel_inc;
  logic [ADDR_W-1:0] sel_cbase;
  logic              exec_ok;
  err_t              exec_err;
  logic              exec_pop;
  logic              exec_push;

  // Multiply-add step
  logic              calc_ok;
  err_t              calc_err;
  logic [IDX_W-1:0]  calc_granted;
  logic [INC_W-1:0]  calc_inc;
  logic [ADDR_W-1:0] calc_cbase;
  logic [ADDR_W-1:0] calc_gbase;
  logic              calc_gpu_en;
  logic [IDX_W+INC_W-1:0] calc_prod;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      srv_increment <= INC_W'(32);
      rtv_increment <= INC_W'(32);
      dsv_increment <= INC_W'(32);
      srv_cpu_base  <= '0;
      rtv_cpu_base  <= '0;
      dsv_cpu_base  <= '0;
      srv_gpu_base  <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SRV_INC:      srv_increment <= cfg_data[INC_W-1:0];
        REG_RTV_INC:      rtv_increment <= cfg_data[INC_W-1:0];
        REG_DSV_INC:      dsv_increment <= cfg_data[INC_W-1:0];
        REG_SRV_CPU_BASE: srv_cpu_base  <= cfg_data;
        REG_RTV_CPU_BASE: rtv_cpu_base  <= cfg_data;
        REG_DSV_CPU_BASE: dsv_cpu_base  <= cfg_data;
        REG_SRV_GPU_BASE: srv_gpu_base  <= cfg_data;
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence one request through read, decide and multiply-add
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_CALC;
      end
      ST_CALC: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_action <= action_t'(action);
      req_pool   <= pool_t'(pool);
      req_index  <= slot_index;
    end
  end

  // Select the addressed pool
  always_comb begin
    unique case (req_pool)
      POOL_RTV: begin
        sel_stat  = rtv_stat;
        sel_slots = (IDX_W+1)'(RTV_SLOTS);
        sel_inc   = rtv_increment;
        sel_cbase = rtv_cpu_base;
      end
      POOL_DSV: begin
        sel_stat  = dsv_stat;
        sel_slots = (IDX_W+1)'(DSV_SLOTS);
        sel_inc   = dsv_increment;
        sel_cbase = dsv_cpu_base;
      end
      default: begin
        sel_stat  = srv_stat;
        sel_slots = (IDX_W+1)'(SRV_SLOTS);
        sel_inc   = srv_increment;
        sel_cbase = srv_cpu_base;
      end
    endcase
  end

  // Decide pop, push or fault
  always_comb begin
    exec_ok   = 1'b0;
    exec_err  = ERR_NONE;
    exec_pop  = 1'b0;
    exec_push = 1'b0;
    priority if (req_pool == POOL_BAD) begin
      exec_err = ERR_BAD_POOL;
    end else if (req_action == ACT_ALLOC) begin
      if (sel_stat.empty) begin
        exec_err = ERR_EMPTY;
      end else begin
        exec_pop = 1'b1;
        exec_ok  = 1'b1;
      end
    end else begin
      priority if ({1'b0, req_index} >= sel_slots) begin
        exec_err = ERR_RANGE;
      end else if (sel_stat.full) begin
        exec_err = ERR_FULL;
      end else begin
        exec_push = 1'b1;
        exec_ok   = 1'b1;
      end
    end
  end

  // Drive the stack commands during the decision step
  always_comb begin
    srv_cmd.index = req_index;
    rtv_cmd.index = req_index;
    dsv_cmd.index = req_index;
    srv_cmd.pop   = (state == ST_EXEC) && exec_pop  && (req_pool == POOL_SRV);
    srv_cmd.push  = (state == ST_EXEC) && exec_push && (req_pool == POOL_SRV);
    rtv_cmd.pop   = (state == ST_EXEC) && exec_pop  && (req_pool == POOL_RTV);
    rtv_cmd.push  = (state == ST_EXEC) && exec_push && (req_pool == POOL_RTV);
    dsv_cmd.pop   = (state == ST_EXEC) && exec_pop  && (req_pool == POOL_DSV);
    dsv_cmd.push  = (state == ST_EXEC) && exec_push && (req_pool == POOL_DSV);
  end

  dsfl_stack #(.SLOTS(SRV_SLOTS)) u_srv_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (srv_cmd),
    .stat (srv_stat)
  );

  dsfl_stack #(.SLOTS(RTV_SLOTS)) u_rtv_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (rtv_cmd),
    .stat (rtv_stat)
  );

  dsfl_stack #(.SLOTS(DSV_SLOTS)) u_dsv_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (dsv_cmd),
    .stat (dsv_stat)
  );

  // Register operands for the handle step; zero the granted index, CPU
  // base and GPU enable unless a slot was granted so the handles come out zero
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      calc_ok      <= exec_ok;
      calc_err     <= exec_err;
      calc_granted <= exec_pop ? sel_stat.top_index : '0;
      calc_inc     <= sel_inc;
      calc_cbase   <= exec_pop ? sel_cbase : '0;
      calc_gbase   <= srv_gpu_base;
      calc_gpu_en  <= exec_pop && (req_pool == POOL_SRV) && SRV_SHADER_VISIBLE;
    end
  end

  assign calc_prod = calc_granted * calc_inc;

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ok            <= calc_ok;
      error_code    <= calc_err;
      granted_index <= calc_granted;
      cpu_handle    <= calc_cbase + ADDR_W'(calc_prod);
      gpu_handle    <= calc_gpu_en ? (calc_gbase + ADDR_W'(calc_prod)) : '0;
    end
  end

  `DSFL_ASSERT_NEXT(a_accept_to_exec, clk, rst, in_valid && in_ready, state == ST_EXEC)
  `DSFL_ASSERT_IMPLY(a_ok_no_error, clk, rst, out_valid && ok, error_code == ERR_NONE)
  `DSFL_ASSERT_IMPLY(a_fail_zero, clk, rst, out_valid && !ok,
                     (cpu_handle == '0) && (granted_index == '0) && (gpu_handle == '0))

endmodule

### design/dsfl_stack.sv
// One LIFO free-list stack of slot indices held in a synchronous memory.
`include "descriptor_slot_free_list_allocator_defines.svh"

module dsfl_stack #(
  parameter int SLOTS = dsfl_pkg::RTV_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dsfl_pkg::stack_cmd_t  cmd,
  output dsfl_pkg::stack_stat_t stat
);
  import dsfl_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW = $clog2(SLOTS + 1);

  logic [AW-1:0] mem [SLOTS];
  logic [TW-1:0] top;
  logic [TW-1:0] lowmark;
  logic [TW-1:0] top_dec;
  logic [TW-1:0] fill_val;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_data;
  logic [AW-1:0] rd_fill;
  logic          rd_hit;

  assign top_dec  = top - TW'(1);
  assign fill_val = TW'(SLOTS) - top;
  assign rd_addr  = top_dec[AW-1:0];
  assign wr_addr  = top[AW-1:0];

  // Track the top and the lowest top reached; entries at or above the
  // low mark have been written since reset, entries below still hold
  // their reset index SLOTS-1-position.
  always_ff @(posedge clk) begin
    if (rst) begin
      top     <= TW'(SLOTS);
      lowmark <= TW'(SLOTS);
    end else if (cmd.pop) begin
      top <= top_dec;
      if (top_dec < lowmark) begin
        lowmark <= top_dec;
      end
    end else if (cmd.push) begin
      top <= top + TW'(1);
    end
  end

  // Write back a freed index at the current top.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= cmd.index[AW-1:0];
    end
  end

  // Read the top entry unless empty, its written flag and reset value always.
  always_ff @(posedge clk) begin
    if (top != '0) begin
      rd_data <= mem[rd_addr];
    end
    rd_hit  <= (top > lowmark);
    rd_fill <= fill_val[AW-1:0];
  end

  assign stat.empty     = (top == '0);
  assign stat.full      = (top == TW'(SLOTS));
  assign stat.top_index = IDX_W'(rd_hit ? rd_data : rd_fill);

  `DSFL_ASSERT_ALWAYS(a_top_bound, clk, rst, top <= TW'(SLOTS))
  `DSFL_ASSERT_ALWAYS(a_lowmark_below_top, clk, rst, lowmark <= top)
  `DSFL_ASSERT_ALWAYS(a_no_push_and_pop, clk, rst, !(cmd.push && cmd.pop))

endmodule
